// ----- design/lags_pkg.sv -----
`default_nettype none

package lags_pkg;

    // Default grid size.
    localparam int ROWS_DEF = 16;
    localparam int COLS_DEF = 32;

    // Widths of the command and result beats.
    localparam int CMD_W     = 2;
    localparam int ROW_IDX_W = 4;
    localparam int CELLS_W   = 32;

    // Widest row that the grid can hold.
    localparam int MAX_W = 64;

    // Neighbor counts of rule B3/S23.
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

endpackage

`default_nettype wire

// ----- design/lags_if.sv -----
`default_nettype none

interface lags_cmd_if;
    import lags_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [ROW_IDX_W-1:0] row_index;
    logic [CELLS_W-1:0]   row_cells_in;

    modport source (output valid, output command, output row_index, output row_cells_in,
                    input ready);
    modport sink (input valid, input command, input row_index, input row_cells_in,
                  output ready);
endinterface

interface lags_row_if;
    import lags_pkg::*;

    logic               valid;
    logic               ready;
    logic [CELLS_W-1:0] row_cells_out;

    modport source (output valid, output row_cells_out, input ready);
    modport sink (input valid, input row_cells_out, output ready);
endinterface

`default_nettype wire

// ----- design/lags_row_unit.sv -----
`default_nettype none

// Next generation of one row from the old rows above, at and below it.
// The first and last columns pass through unchanged.
module lags_row_unit import lags_pkg::*; #(
    parameter int COLS = COLS_DEF
) (
    input  logic [COLS-1:0] i_above,
    input  logic [COLS-1:0] i_mid,
    input  logic [COLS-1:0] i_below,
    output logic [COLS-1:0] o_next
);

    always_comb begin : p_rule
        logic [3:0] nbr;
        nbr    = '0;
        o_next = i_mid;
        for (int c = 1; c < COLS - 1; c++) begin
            nbr = 4'(i_above[c-1]) + 4'(i_above[c]) + 4'(i_above[c+1])
                + 4'(i_mid[c-1])                    + 4'(i_mid[c+1])
                + 4'(i_below[c-1]) + 4'(i_below[c]) + 4'(i_below[c+1]);
            o_next[c] = (nbr == BIRTH_COUNT) || (i_mid[c] && (nbr == KEEP_COUNT));
        end
    end

endmodule

`default_nettype wire

// ----- design/life_automaton_grid_step_unit.sv -----
// Channel   Dir  Modport  Payload                                  Beat means
// i_cmd     in   sink     command, row_index, row_cells_in         one command
// o_res     out  source   row_cells_out                            one row read back
//
// A write is stored when it is taken; a read goes through S_RDATA, then waits for
// o_res.ready in S_RESULT. In a step the grid row memory has one read port, so the
// sequencer streams the rows through a three-row window, one row a cycle, and the
// shared row unit writes back each interior row once its old neighbors are in it.
// i_cmd.ready is low while a step or a read is in progress or a result waits.
// Reset (synchronous, active low) marks every row invalid, so all cells read dead.
`default_nettype none

module life_automaton_grid_step_unit import lags_pkg::*; #(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lags_cmd_if.sink    i_cmd,
    lags_row_if.source  o_res
);

    // Row address, step counter (it must reach ROWS + 1) and a width that holds both
    // the command's row index and ROWS for the range compare.
    localparam int AW = $clog2(ROWS);
    localparam int CW = $clog2(ROWS + 2);
    localparam int XW = ((CW > ROW_IDX_W) ? CW : ROW_IDX_W) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STEP,
        S_RDATA,
        S_RESULT
    } t_state;

    t_state             r_state;
    logic [CW-1:0]      r_cnt;
    logic               r_out_valid;
    logic [CELLS_W-1:0] r_out;
    logic               r_rd_ok;

    // Grid storage: one row per entry, with a valid bit per row so that reset
    // clears the whole grid at once.
    logic [COLS-1:0]    r_mem [ROWS];
    logic [ROWS-1:0]    r_vld;
    logic [COLS-1:0]    r_rdata;
    logic               r_rvld;

    // Window of three old rows for the step.
    logic [COLS-1:0]    r_above;
    logic [COLS-1:0]    r_mid;
    logic [COLS-1:0]    r_below;

    logic               in_ready;
    logic               in_acc;
    logic [XW-1:0]      in_row_x;
    logic               in_row_ok;
    logic [MAX_W-1:0]   in_cells_x;
    logic [MAX_W-1:0]   rdata_x;
    logic [COLS-1:0]    rd_eff;
    logic [CW-1:0]      cnt_m3;
    logic [COLS-1:0]    next_row;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COLS-1:0]    wr_data;

    assign in_ready       = (r_state == S_IDLE);
    assign in_acc         = i_cmd.valid && in_ready;
    assign i_cmd.ready    = in_ready;
    assign o_res.valid    = r_out_valid;
    assign o_res.row_cells_out = r_out;

    assign in_row_x   = XW'(i_cmd.row_index);
    assign in_row_ok  = in_row_x < XW'(ROWS);
    assign in_cells_x = MAX_W'(i_cmd.row_cells_in);
    assign rdata_x    = MAX_W'(r_rdata);
    assign rd_eff     = r_rvld ? r_rdata : '0;
    assign cnt_m3     = r_cnt - CW'(3);

    lags_row_unit #(
        .COLS (COLS)
    ) u_row (
        .i_above (r_above),
        .i_mid   (r_mid),
        .i_below (r_below),
        .o_next  (next_row)
    );

    // Port selection. During a step, count value c reads row c, and from c = 4 on it
    // writes back row c - 3, whose old neighbors are then all in the window.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = in_row_x[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = in_row_x[AW-1:0];
        wr_data = in_cells_x[COLS-1:0];
        if (r_state == S_STEP) begin
            rd_en   = r_cnt < CW'(ROWS);
            rd_addr = r_cnt[AW-1:0];
            wr_en   = r_cnt >= CW'(4);
            wr_addr = cnt_m3[AW-1:0];
            wr_data = next_row;
        end else if (in_acc && in_row_ok) begin
            rd_en = (i_cmd.command == CMD_READ);
            wr_en = (i_cmd.command == CMD_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
            r_rvld  <= r_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // The window shifts one old row in per cycle once the first read returns.
    always_ff @(posedge i_clk) begin
        if (r_state == S_STEP && r_cnt != '0) begin
            r_above <= r_mid;
            r_mid   <= r_below;
            r_below <= rd_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_cmd.command)
                            CMD_STEP: begin
                                r_state <= S_STEP;
                                r_cnt   <= '0;
                            end
                            CMD_READ: begin
                                r_state <= S_RDATA;
                                r_rd_ok <= in_row_ok;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(ROWS + 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RDATA: begin
                    // A row outside the grid or never written reads as all dead.
                    r_out       <= (r_rd_ok && r_rvld) ? rdata_x[CELLS_W-1:0] : '0;
                    r_out_valid <= 1'b1;
                    r_state     <= S_RESULT;
                end
                S_RESULT: begin
                    if (o_res.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/lags_checker.sv -----
`default_nettype none

module lags_checker import lags_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                i_in_ready,
    input wire logic [CMD_W-1:0]    i_command,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire logic [CELLS_W-1:0]  i_row_cells_out
);

    logic in_acc;
    logic rd_acc;

    assign in_acc = i_in_valid && i_in_ready;
    assign rd_acc = in_acc && (i_command == CMD_READ);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its row bits.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_row_cells_out))
        else $error("result changed while stalled");

    // Every read that is taken shows its row.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_acc |=> ##1 i_out_valid)
        else $error("read gave no result");

    // A result only ever appears as the answer to a read.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(rd_acc, 2))
        else $error("result without a read");

    // No new command is taken while a result waits.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !in_acc)
        else $error("command taken while result pending");

endmodule

bind life_automaton_grid_step_unit lags_checker u_lags_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_cmd.valid),
    .i_in_ready      (i_cmd.ready),
    .i_command       (i_cmd.command),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_row_cells_out (o_res.row_cells_out)
);

`default_nettype wire
